/* design/numeric_literal_parser_top_macros.svh */
// Assertion macros shared by the numeric literal parser RTL.
`ifndef NUMERIC_LITERAL_PARSER_TOP_MACROS_SVH
`define NUMERIC_LITERAL_PARSER_TOP_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define NLP_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define NLP_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/nlp_pkg.sv */
// Package with types and constants of the numeric literal parser.
package nlp_pkg;

  localparam int VALUE_BITS_DEFAULT = 32;
  localparam int CFG_INDEX_BITS     = 2;
  localparam int CFG_DATA_BITS      = 7;
  localparam int RADIX_BITS         = 6;
  localparam int FRAC_BITS          = 7;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_BASE_SELECT     = 2'd0,
    REG_FRACTION_DIGITS = 2'd1,
    REG_SIGNED_MODE     = 2'd2
  } cfg_reg_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CHAR,
    S_PAD,
    S_FIN
  } state_t;

  typedef enum logic [2:0] {
    PH_START,
    PH_SIGNED,
    PH_ZERO,
    PH_OPEN,
    PH_DOT,
    PH_DIGITS
  } phase_t;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UB    = 8'h42;
  localparam logic [7:0] CH_UO    = 8'h4F;
  localparam logic [7:0] CH_UX    = 8'h58;
  localparam logic [7:0] CH_UZ    = 8'h5A;
  localparam logic [7:0] CASE_BIT = 8'h20;
  // 'A' maps to digit 10
  localparam logic [7:0] ALPHA_OFFSET = 8'd55;

  localparam logic [RADIX_BITS-1:0] RADIX_MIN = 6'd2;
  localparam logic [RADIX_BITS-1:0] RADIX_MAX = 6'd36;
  localparam logic [RADIX_BITS-1:0] RADIX_BIN = 6'd2;
  localparam logic [RADIX_BITS-1:0] RADIX_OCT = 6'd8;
  localparam logic [RADIX_BITS-1:0] RADIX_DEC = 6'd10;
  localparam logic [RADIX_BITS-1:0] RADIX_HEX = 6'd16;

endpackage

/* design/nlp_channels.sv */
// Handshake channel interfaces of the numeric literal parser.
interface nlp_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] character;

  modport source (output valid, output character, input ready);
  modport sink   (input valid, input character, output ready);
endinterface

interface nlp_result_if #(
  parameter int VALUE_BITS = nlp_pkg::VALUE_BITS_DEFAULT
);
  logic                  valid;
  logic                  ready;
  logic [VALUE_BITS-1:0] value;
  logic                  valid_res;

  modport source (output valid, output value, output valid_res, input ready);
  modport sink   (input valid, input value, input valid_res, output ready);
endinterface

interface nlp_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [nlp_pkg::CFG_INDEX_BITS-1:0] index;
  logic [nlp_pkg::CFG_DATA_BITS-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

/* design/numeric_literal_parser_top.sv */
// Top level of the streaming numeric literal parser.
//
// Channels: chars takes one ASCII character per beat; a NUL character ends
// the literal. result delivers one beat per literal: value (two's complement
// when negative, 0 on error) and valid_res. cfg writes base_select (0),
// fraction_digits (1) and signed_mode (2); it is always ready.
// Steps: an ordinary character is accepted, then decoded and passed once
// through the shared multiply-add unit; chars.ready is low meanwhile.
// A terminator passes the decode step, then pads P, the fraction digits still
// to pad: each padding zero is one more pass through the same multiply-add
// unit, which sets the rate. The final step then loads the result.
// The result sits in an output register; while it waits, the next literal's
// characters are still taken. A second terminator holds in the final step
// until the receiver takes the earlier result.
// Reset: synchronous, clears configuration to zero, the literal state and the
// output valid flag. No clearing pass is needed.
`include "numeric_literal_parser_top_macros.svh"

module numeric_literal_parser_top #(
  parameter int VALUE_BITS = nlp_pkg::VALUE_BITS_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst,
  nlp_char_if.sink             chars,
  nlp_result_if.source         result,
  nlp_cfg_if.sink              cfg
);

  localparam int RB = nlp_pkg::RADIX_BITS;
  localparam int FB = nlp_pkg::FRAC_BITS;
  localparam int WW = VALUE_BITS + RB;
  localparam logic [VALUE_BITS-1:0] SIGN_BIT = {1'b1, {(VALUE_BITS-1){1'b0}}};

  // configuration
  logic [RB-1:0] base_select;
  logic [FB-1:0] fraction_digits;
  logic          signed_mode;

  // literal state
  nlp_pkg::state_t  state, state_next;
  nlp_pkg::phase_t  phase, phase_next;
  logic [VALUE_BITS-1:0] accumulator, acc_next;
  logic          negative_flag, neg_next;
  logic [RB-1:0] active_radix, radix_next;
  logic          in_fraction, infrac_next;
  logic [FB-1:0] fraction_left, fl_next;
  logic          error_flag, err_next;
  logic [7:0]    char_q;

  // output register
  logic                  out_valid;
  logic [VALUE_BITS-1:0] out_value;
  logic                  out_ok;

  // character decode
  logic [7:0]    up;
  logic          dig_num, dig_alpha, dig_ok;
  logic [RB-1:0] dig_val;

  // start of body
  logic          sb, izero, do_bc, first;
  logic [RB-1:0] pfx, sb_radix;
  logic          sb_err;

  // shared multiply-add unit
  logic [RB-1:0] mu_radix, mu_inc;
  logic [WW-1:0] mu_wide;
  logic          mu_err;

  // finish
  logic                  pad_ok, fin_go, fin_ok;
  logic [VALUE_BITS-1:0] fin_value;

  logic in_beat, out_beat, cfg_beat;

  assign in_beat  = chars.valid && chars.ready;
  assign out_beat = result.valid && result.ready;
  assign cfg_beat = cfg.valid && cfg.ready;

  assign up        = char_q & ~nlp_pkg::CASE_BIT;
  assign dig_num   = (char_q >= nlp_pkg::CH_0) && (char_q <= nlp_pkg::CH_9);
  assign dig_alpha = (char_q > nlp_pkg::CH_9) && (up >= nlp_pkg::CH_UA)
                     && (up <= nlp_pkg::CH_UZ);
  assign dig_ok    = dig_num || dig_alpha;
  assign dig_val   = dig_num ? RB'(char_q - nlp_pkg::CH_0)
                             : RB'(up - nlp_pkg::ALPHA_OFFSET);

  assign sb_radix = (pfx != '0) ? pfx
                  : ((base_select != '0) ? base_select : nlp_pkg::RADIX_DEC);
  assign sb_err   = ((pfx != '0) && (base_select != '0) && (base_select != pfx))
                    || (sb_radix < nlp_pkg::RADIX_MIN)
                    || (sb_radix > nlp_pkg::RADIX_MAX);

  // acc * radix + inc; error on overflow (any bit above the value width set) or on a radix out of range
  assign mu_wide = ({{RB{1'b0}}, accumulator} * {{VALUE_BITS{1'b0}}, mu_radix})
                   + {{VALUE_BITS{1'b0}}, mu_inc};
  assign mu_err  = (mu_radix < nlp_pkg::RADIX_MIN) || (mu_radix > nlp_pkg::RADIX_MAX)
                   || (|mu_wide[WW-1:VALUE_BITS]);

  assign pad_ok = !error_flag && (phase == nlp_pkg::PH_DIGITS);
  assign fin_go = (state == nlp_pkg::S_FIN) && (!out_valid || result.ready);

  always_comb begin
    fin_ok    = pad_ok;
    fin_value = accumulator;
    if (negative_flag) begin
      if (signed_mode ? (accumulator > SIGN_BIT) : (accumulator != '0)) begin
        fin_ok = 1'b0;
      end
      fin_value = '0 - accumulator;
    end else if (signed_mode && accumulator[VALUE_BITS-1]) begin
      fin_ok = 1'b0;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      nlp_pkg::S_IDLE: if (in_beat) state_next = nlp_pkg::S_CHAR;
      nlp_pkg::S_CHAR: begin
        state_next = (char_q == nlp_pkg::CH_NUL) ? nlp_pkg::S_PAD : nlp_pkg::S_IDLE;
      end
      nlp_pkg::S_PAD: if (!pad_ok || fraction_left == '0) state_next = nlp_pkg::S_FIN;
      nlp_pkg::S_FIN: if (fin_go) state_next = nlp_pkg::S_IDLE;
      default: state_next = nlp_pkg::S_IDLE;
    endcase
  end

  // handshake outputs
  always_comb begin
    chars.ready      = (state == nlp_pkg::S_IDLE);
    cfg.ready        = 1'b1;
    result.valid     = out_valid;
    result.value     = out_value;
    result.valid_res = out_ok;
  end

  // literal datapath
  always_comb begin
    acc_next    = accumulator;
    phase_next  = phase;
    neg_next    = negative_flag;
    radix_next  = active_radix;
    infrac_next = in_fraction;
    fl_next     = fraction_left;
    err_next    = error_flag;
    sb          = 1'b0;
    izero       = 1'b0;
    do_bc       = 1'b0;
    first       = 1'b0;
    pfx         = '0;
    mu_radix    = active_radix;
    mu_inc      = '0;
    unique case (state)
      nlp_pkg::S_CHAR: begin
        if (char_q == nlp_pkg::CH_NUL) begin
          // a lone zero becomes the body at the terminator
          if (phase == nlp_pkg::PH_ZERO && !error_flag) begin
            sb    = 1'b1;
            izero = 1'b1;
          end
        end else if (!error_flag) begin
          priority if (phase == nlp_pkg::PH_START &&
                       (char_q == nlp_pkg::CH_PLUS || char_q == nlp_pkg::CH_MINUS)) begin
            neg_next   = (char_q == nlp_pkg::CH_MINUS);
            phase_next = nlp_pkg::PH_SIGNED;
          end else if (phase == nlp_pkg::PH_START || phase == nlp_pkg::PH_SIGNED) begin
            if (char_q == nlp_pkg::CH_0) begin
              phase_next = nlp_pkg::PH_ZERO;
            end else begin
              sb    = 1'b1;
              do_bc = 1'b1;
            end
          end else if (phase == nlp_pkg::PH_ZERO) begin
            sb = 1'b1;
            priority if (up == nlp_pkg::CH_UX) begin
              pfx = nlp_pkg::RADIX_HEX;
            end else if (up == nlp_pkg::CH_UB) begin
              pfx = nlp_pkg::RADIX_BIN;
            end else if (up == nlp_pkg::CH_UO) begin
              pfx = nlp_pkg::RADIX_OCT;
            end else begin
              // leading zero was a digit; it leaves the accumulator at zero
              izero = 1'b1;
              do_bc = 1'b1;
            end
          end else begin
            do_bc = 1'b1;
          end
        end
        if (sb) begin
          radix_next = sb_radix;
          fl_next    = fraction_digits;
          err_next   = sb_err;
          phase_next = izero ? nlp_pkg::PH_DIGITS : nlp_pkg::PH_OPEN;
        end
        if (do_bc && !err_next) begin
          first      = (phase_next == nlp_pkg::PH_OPEN);
          phase_next = nlp_pkg::PH_DIGITS;
          if (char_q == nlp_pkg::CH_DOT) begin
            if (in_fraction || fraction_digits == '0) begin
              err_next = 1'b1;
            end else begin
              infrac_next = 1'b1;
              if (first) phase_next = nlp_pkg::PH_DOT;
            end
          end else if (!dig_ok || dig_val >= radix_next) begin
            err_next = 1'b1;
          end else begin
            // surplus fraction digits are checked but dropped
            if (!in_fraction || fl_next != '0) begin
              mu_radix = radix_next;
              mu_inc   = dig_val;
              if (mu_err) err_next = 1'b1;
              else        acc_next = mu_wide[VALUE_BITS-1:0];
            end
            if (in_fraction && fl_next != '0) fl_next = fl_next - FB'(1);
          end
        end
      end
      nlp_pkg::S_PAD: begin
        if (pad_ok && fraction_left != '0) begin
          mu_radix    = active_radix;
          mu_inc      = '0;
          infrac_next = 1'b1;
          fl_next     = fraction_left - FB'(1);
          if (mu_err) err_next = 1'b1;
          else        acc_next = mu_wide[VALUE_BITS-1:0];
        end
      end
      nlp_pkg::S_FIN: begin
        if (fin_go) begin
          acc_next    = '0;
          phase_next  = nlp_pkg::PH_START;
          neg_next    = 1'b0;
          radix_next  = '0;
          infrac_next = 1'b0;
          fl_next     = '0;
          err_next    = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= nlp_pkg::S_IDLE;
      phase         <= nlp_pkg::PH_START;
      accumulator   <= '0;
      negative_flag <= 1'b0;
      active_radix  <= '0;
      in_fraction   <= 1'b0;
      fraction_left <= '0;
      error_flag    <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      state         <= state_next;
      phase         <= phase_next;
      accumulator   <= acc_next;
      negative_flag <= neg_next;
      active_radix  <= radix_next;
      in_fraction   <= infrac_next;
      fraction_left <= fl_next;
      error_flag    <= err_next;
      if (fin_go) begin
        out_valid <= 1'b1;
      end else if (out_beat) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_beat) char_q <= chars.character;
    if (fin_go) begin
      out_ok    <= fin_ok;
      out_value <= fin_ok ? fin_value : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      base_select     <= '0;
      fraction_digits <= '0;
      signed_mode     <= 1'b0;
    end else if (cfg_beat) begin
      unique case (cfg.index)
        nlp_pkg::REG_BASE_SELECT:     base_select     <= cfg.data[RB-1:0];
        nlp_pkg::REG_FRACTION_DIGITS: fraction_digits <= cfg.data[FB-1:0];
        nlp_pkg::REG_SIGNED_MODE:     signed_mode     <= cfg.data[0];
        default: begin
        end
      endcase
    end
  end

  `NLP_ASSERT_NXT(a_beat_to_char, clk, rst, in_beat, state == nlp_pkg::S_CHAR,
                  "character beat not followed by decode step")
  `NLP_ASSERT_NXT(a_fin_loads_out, clk, rst, fin_go, result.valid,
                  "finished literal did not reach the output register")
  `NLP_ASSERT_IMP(a_error_zero, clk, rst, result.valid && !result.valid_res,
                  result.value == '0, "failed literal carries a nonzero value")
  `NLP_ASSERT_IMP(a_pad_needs_digits, clk, rst,
                  state == nlp_pkg::S_PAD && fraction_left != '0 && !error_flag,
                  phase != nlp_pkg::PH_START && phase != nlp_pkg::PH_ZERO,
                  "padding zeros before any body")

endmodule
